FILE: hw/rtl/gbcf_pkg.sv
// Shared types and constants for the grid blank-cell finder.
// Used by gbcf_divider, gbcf_cell_store and grid_blank_cell_finder.
package gbcf_pkg;

    localparam int FRAC_W    = 16;                       // Q16.16 fraction bits
    localparam int EPS_LSBS  = 7;                        // 0.0001 in quotient LSBs
    localparam int NEG_LIMIT = (1 << FRAC_W) + EPS_LSBS; // negative quotients below map to 0
    localparam int STEP_W    = 31;
    localparam int DIM_W     = 9;
    localparam int CFG_IDX_W = 3;

    // values at or above -9998.0 in Q24.8 mark a cell as filled
    localparam logic signed [31:0] FILL_LIMIT = -32'sd2559488;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_SCAN  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WEST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_SOUTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_LON   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_LAT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS   = 3'd5;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef struct packed {
        logic wr_en;
        logic wr_data;
        logic clear;
    } t_store_req;

endpackage

FILE: hw/rtl/grid_blank_cell_finder.sv
// Grid blank-cell finder: bins points into a grid and scans it for blank cells.
// Add point: two QW-bit divisions on the shared divider (QW = 16 + index bits)
// give row and column. Scan: a division sets up row and column from the cursor,
// then blank cells are emitted with their centres as the output frees, then a
// closing word. Reset and clear: the cell store sweeps MAX_ROWS*MAX_COLS cells
// (65536 at defaults), taking no item meanwhile; configuration is always taken.
module grid_blank_cell_finder import gbcf_pkg::*; #(
    parameter int MAX_ROWS   = 256,
    parameter int MAX_COLS   = 256,
    parameter int SCAN_CHUNK = 63
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [95:0]          s_axis_tdata,   // point_lon, point_lat, point_value
    input  logic [1:0]           s_axis_tuser,   // operation
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [63:0]          m_axis_tdata,   // cell_lon, cell_lat
    output logic [1:0]           m_axis_tuser,   // is_blank, scan_done
    output logic                 m_axis_tlast,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    localparam int RCW   = $clog2(MAX_ROWS + 1);
    localparam int CCW   = $clog2(MAX_COLS + 1);
    localparam int IXW   = (RCW > CCW) ? RCW : CCW;
    localparam int QW    = FRAC_W + IXW;
    localparam int NUM_W = STEP_W + QW;
    localparam int OVW   = 32 + IXW;
    localparam int FW    = IXW + 1;
    localparam int PW    = FW + STEP_W;
    localparam int SW    = PW + 1;
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int KW    = $clog2(SCAN_CHUNK + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_LAT_START, S_LAT_WAIT, S_LON_START, S_LON_WAIT, S_WRITE,
        S_SCAN_START, S_SCAN_WAIT, S_CELL_RD, S_CELL_CHK, S_SUM_LON, S_SUM_LAT,
        S_EMIT, S_ADVANCE, S_CLOSE
    } t_state;

    // configuration
    logic signed [31:0] r_grid_west;
    logic signed [31:0] r_grid_south;
    logic [STEP_W-1:0]  r_step_lon;
    logic [STEP_W-1:0]  r_step_lat;
    logic [DIM_W-1:0]   r_num_rows;
    logic [DIM_W-1:0]   r_num_cols;

    // sequencer
    t_state             r_state;
    logic [31:0]        r_lon;
    logic [31:0]        r_lat;
    logic signed [31:0] r_value;
    logic               r_neg;
    logic [RCW-1:0]     r_row;
    logic [CCW-1:0]     r_col;
    logic [CW-1:0]      r_cursor;
    logic [CW-1:0]      r_total;
    logic [KW-1:0]      r_count;
    logic [PW-1:0]      r_prod;
    logic [31:0]        r_cell_lon;
    logic [31:0]        r_cell_lat;
    logic               r_out_valid;
    logic [63:0]        r_out_data;
    logic [1:0]         r_out_user;
    logic               r_out_last;

    logic [RCW-1:0]     w_rows;
    logic [CCW-1:0]     w_cols;
    logic [STEP_W-1:0]  w_step_lon;
    logic [STEP_W-1:0]  w_step_lat;
    logic               w_in_acc;
    logic               w_out_free;
    logic               w_sel_lat;
    logic [31:0]        w_pos;
    logic [31:0]        w_edge;
    logic [STEP_W-1:0]  w_step;
    logic signed [32:0] w_diff;
    logic [31:0]        w_abs;
    logic               w_ovf;
    logic               w_div_start;
    logic [NUM_W-1:0]   w_div_num;
    logic [STEP_W-1:0]  w_div_den;
    t_div_stat          w_div_stat;
    logic [QW-1:0]      w_quo;
    logic [STEP_W-1:0]  w_rem;
    logic [QW:0]        w_idx_sum;
    logic [IXW:0]       w_idx;
    logic [31:0]        w_idx_lim;
    logic               w_idx_ok;
    logic [FW-1:0]      w_factor;
    logic [STEP_W-1:0]  w_mstep;
    logic [PW-1:0]      w_prod;
    logic [31:0]        w_cedge;
    logic signed [SW-1:0] w_sum;
    logic [31:0]        w_centre;
    logic [AW-1:0]      w_addr;
    t_store_req         w_store_req;
    logic               w_rd_data;
    logic               w_store_busy;
    logic               w_last_cell;

    function automatic logic [31:0] sat32(input logic signed [SW-1:0] v);
        logic hi_pos;
        logic hi_neg;
        hi_pos = !v[SW-1] && (|v[SW-2:31]);
        hi_neg = v[SW-1] && !(&v[SW-2:31]);
        if (hi_pos) begin
            return 32'h7fff_ffff;
        end else if (hi_neg) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // configuration port
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_west  <= '0;
            r_grid_south <= '0;
            r_step_lon   <= STEP_W'(65536);
            r_step_lat   <= STEP_W'(65536);
            r_num_rows   <= DIM_W'(256);
            r_num_cols   <= DIM_W'(256);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_GRID_WEST:  r_grid_west  <= i_cfg_data;
                REG_GRID_SOUTH: r_grid_south <= i_cfg_data;
                REG_STEP_LON:   r_step_lon   <= i_cfg_data[STEP_W-1:0];
                REG_STEP_LAT:   r_step_lat   <= i_cfg_data[STEP_W-1:0];
                REG_NUM_ROWS:   r_num_rows   <= i_cfg_data[DIM_W-1:0];
                REG_NUM_COLS:   r_num_cols   <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_rows     = (32'(r_num_rows) > 32'(MAX_ROWS)) ? RCW'(MAX_ROWS) : RCW'(r_num_rows);
        w_cols     = (32'(r_num_cols) > 32'(MAX_COLS)) ? CCW'(MAX_COLS) : CCW'(r_num_cols);
        w_step_lon = (r_step_lon == '0) ? STEP_W'(1) : r_step_lon;
        w_step_lat = (r_step_lat == '0) ? STEP_W'(1) : r_step_lat;
    end

    assign s_axis_tready = (r_state == S_IDLE) && !w_store_busy;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    // operand selection for the shared divider
    always_comb begin
        w_sel_lat = (r_state == S_LAT_START);
        w_pos     = w_sel_lat ? r_lat : r_lon;
        w_edge    = w_sel_lat ? r_grid_south : r_grid_west;
        w_step    = w_sel_lat ? w_step_lat : w_step_lon;
        w_diff    = $signed({w_pos[31], w_pos}) - $signed({w_edge[31], w_edge});
        w_abs     = w_diff[32] ? 32'(-w_diff) : w_diff[31:0];
        // quotient would not fit: index is out of range whatever the sign
        w_ovf     = OVW'(w_abs) >= OVW'({w_step, {IXW{1'b0}}});

        if (r_state == S_SCAN_START) begin
            w_div_num   = NUM_W'(r_cursor);
            w_div_den   = STEP_W'(w_cols);
            w_div_start = (r_cursor < r_total);
        end else begin
            w_div_num   = NUM_W'({w_abs, {FRAC_W{1'b0}}});
            w_div_den   = w_step;
            w_div_start = ((r_state == S_LAT_START) || (r_state == S_LON_START)) && !w_ovf;
        end
    end

    gbcf_divider #(
        .QW(QW)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_stat  (w_div_stat),
        .o_quo   (w_quo),
        .o_rem   (w_rem)
    );

    // add epsilon, truncate toward zero, range check
    always_comb begin
        w_idx_sum = {1'b0, w_quo} + (QW + 1)'(EPS_LSBS);
        w_idx     = r_neg ? '0 : w_idx_sum[QW:FRAC_W];
        w_idx_lim = (r_state == S_LAT_WAIT) ? 32'(w_rows) : 32'(w_cols);
        w_idx_ok  = (!r_neg || (w_quo < QW'(NEG_LIMIT))) && (32'(w_idx) < w_idx_lim);
    end

    // centre = edge + ((2*idx + 1) * step) / 2, saturated
    always_comb begin
        w_factor = (r_state == S_CELL_CHK) ? FW'({r_col, 1'b1}) : FW'({r_row, 1'b1});
        w_mstep  = (r_state == S_CELL_CHK) ? w_step_lon : w_step_lat;
        w_prod   = PW'(w_factor) * PW'(w_mstep);
        w_cedge  = (r_state == S_SUM_LON) ? r_grid_west : r_grid_south;
        w_sum    = $signed({{(SW - 32){w_cedge[31]}}, w_cedge})
                 + $signed(SW'(r_prod[PW-1:1]));
        w_centre = sat32(w_sum);
    end

    assign w_addr      = AW'(32'(r_row) * 32'(MAX_COLS) + 32'(r_col));
    assign w_last_cell = (r_count + 1'b1 == KW'(SCAN_CHUNK)) || (r_cursor + 1'b1 == r_total);

    always_comb begin
        w_store_req.wr_en   = (r_state == S_WRITE);
        w_store_req.wr_data = (r_value >= FILL_LIMIT);
        w_store_req.clear   = w_in_acc && (s_axis_tuser == OP_CLEAR);
    end

    gbcf_cell_store #(
        .DEPTH(DEPTH)
    ) u_cell_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_store_req),
        .i_addr    (w_addr),
        .o_rd_data (w_rd_data),
        .o_busy    (w_store_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cursor    <= '0;
            r_total     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_total <= CW'(32'(w_rows) * 32'(w_cols));
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_lon   <= s_axis_tdata[31:0];
                        r_lat   <= s_axis_tdata[63:32];
                        r_value <= s_axis_tdata[95:64];
                        case (s_axis_tuser)
                            OP_ADD:   r_state  <= S_LAT_START;
                            OP_SCAN:  r_state  <= S_SCAN_START;
                            OP_CLEAR: r_cursor <= '0;
                            default: ;
                        endcase
                    end
                end
                S_LAT_START: begin
                    r_neg   <= w_diff[32];
                    r_state <= w_ovf ? S_IDLE : S_LAT_WAIT;
                end
                S_LAT_WAIT: begin
                    if (w_div_stat.done) begin
                        r_row   <= RCW'(w_idx);
                        r_state <= w_idx_ok ? S_LON_START : S_IDLE;
                    end
                end
                S_LON_START: begin
                    r_neg   <= w_diff[32];
                    r_state <= w_ovf ? S_IDLE : S_LON_WAIT;
                end
                S_LON_WAIT: begin
                    if (w_div_stat.done) begin
                        r_col   <= CCW'(w_idx);
                        r_state <= w_idx_ok ? S_WRITE : S_IDLE;
                    end
                end
                S_WRITE: begin
                    r_state <= S_IDLE;
                end
                S_SCAN_START: begin
                    // cursor at or past the end: close at once and leave it
                    r_state <= (r_cursor < r_total) ? S_SCAN_WAIT : S_CLOSE;
                end
                S_SCAN_WAIT: begin
                    if (w_div_stat.done) begin
                        r_row   <= RCW'(w_quo);
                        r_col   <= CCW'(w_rem);
                        r_count <= '0;
                        r_state <= S_CELL_RD;
                    end
                end
                S_CELL_RD: begin
                    r_state <= S_CELL_CHK;
                end
                S_CELL_CHK: begin
                    r_prod  <= w_prod;
                    r_state <= w_rd_data ? S_ADVANCE : S_SUM_LON;
                end
                S_SUM_LON: begin
                    r_cell_lon <= w_centre;
                    r_prod     <= w_prod;
                    r_state    <= S_SUM_LAT;
                end
                S_SUM_LAT: begin
                    r_cell_lat <= w_centre;
                    r_state    <= S_EMIT;
                end
                S_EMIT: begin
                    // hold the word until the output register frees
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_user  <= 2'b01;
                        r_out_last  <= 1'b0;
                        r_out_data  <= {r_cell_lat, r_cell_lon};
                        r_state     <= S_ADVANCE;
                    end
                end
                S_ADVANCE: begin
                    r_cursor <= r_cursor + 1'b1;
                    r_count  <= r_count + 1'b1;
                    if (r_col + 1'b1 == w_cols) begin
                        r_col <= '0;
                        r_row <= r_row + 1'b1;
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                    r_state <= w_last_cell ? S_CLOSE : S_CELL_RD;
                end
                S_CLOSE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= '0;
                        r_out_user  <= {(r_cursor >= r_total), 1'b0};
                        r_out_last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_clear_sweeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (s_axis_tuser == OP_CLEAR)) |=> w_store_busy)
        else $error("clear word did not start the store sweep");

    a_no_write_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_store_req.wr_en |-> !w_store_busy)
        else $error("store write during clearing sweep");

    a_chunk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADVANCE) |-> (r_count < KW'(SCAN_CHUNK)))
        else $error("scan walked past its chunk");

    a_close_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> m_axis_tlast)
        else $error("closing word without tlast");

    a_blank_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (!m_axis_tuser[1] && !m_axis_tlast))
        else $error("blank-cell word flagged as closing");
`endif

endmodule

FILE: hw/rtl/gbcf_divider.sv
// Restoring divider, one quotient bit per cycle, shared by binning and scan setup.
// Depends on gbcf_pkg (STEP_W, t_div_stat).
module gbcf_divider import gbcf_pkg::*; #(
    parameter int QW = 25
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [STEP_W+QW-1:0]   i_num,   // upper part must stay below i_den
    input  logic [STEP_W-1:0]      i_den,
    output t_div_stat              o_stat,
    output logic [QW-1:0]          o_quo,
    output logic [STEP_W-1:0]      o_rem
);

    localparam int NUM_W = STEP_W + QW;
    localparam int CNT_W = $clog2(QW + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [STEP_W-1:0] r_rem;
    logic [QW-1:0]     r_quo;
    logic [STEP_W-1:0] r_den;

    logic [STEP_W:0]   w_trial;
    logic              w_fits;
    logic [STEP_W-1:0] n_rem;

    always_comb begin
        w_trial = {r_rem, r_quo[QW-1]};
        w_fits  = (w_trial >= {1'b0, r_den});
        n_rem   = w_fits ? STEP_W'(w_trial - {1'b0, r_den}) : w_trial[STEP_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[NUM_W-1:QW];
            r_quo <= i_num[QW-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[QW-2:0], w_fits};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;
    assign o_rem       = r_rem;

endmodule

FILE: hw/rtl/gbcf_cell_store.sv
// Filled/blank bit per grid cell, one write (outside a clearing sweep) and one registered read per cycle.
// Clears itself with a sweep after reset and on request. Depends on gbcf_pkg.
module gbcf_cell_store import gbcf_pkg::*; #(
    parameter int DEPTH = 65536
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  t_store_req                               i_req,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    output logic                                     o_rd_data,
    output logic                                     o_busy
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic          r_mem [DEPTH];
    logic          r_rd_data;
    logic          r_busy;
    logic [AW-1:0] r_sweep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b1;
            r_sweep <= '0;
        end else if (i_req.clear) begin
            r_busy  <= 1'b1;
            r_sweep <= '0;
        end else if (r_busy) begin
            if (r_sweep == AW'(DEPTH - 1)) begin
                r_busy <= 1'b0;
            end else begin
                r_sweep <= r_sweep + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_sweep] <= 1'b0;
        end else if (i_req.wr_en) begin
            r_mem[i_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_addr];
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

endmodule
